@@ rtl/pkf_pkg.sv @@
// Shared types, constants and the control store of the position Kalman filter.
// Holds the microcode table read by pkf_sequencer and the control word decoded by pkf_datapath.
// No dependencies.
package pkf_pkg;

    // Field widths
    localparam int POS_W   = 33;   // signed Q9.24 position
    localparam int VAR_W   = 32;   // unsigned Q2.30 variance / noise
    localparam int CFG_W   = 32;
    localparam int DEN_W   = 33;   // p + r
    localparam int REM_W   = 34;   // divider partial remainder
    localparam int K_W     = 31;   // gain, 0 .. 2^30
    localparam int DIFF_W  = 34;   // measurement - estimate
    localparam int MAG_W   = 33;   // |innovation| or p
    localparam int MLO_W   = 17;   // low slice of the multiplicand
    localparam int MHI_W   = 16;   // high slice of the multiplicand
    localparam int PROD_W  = 48;   // one partial product
    localparam int ACC_W   = 63;   // full product
    localparam int D_W     = 34;   // rounded product >> 30
    localparam int SUM_W   = 36;   // estimate + correction
    localparam int FRAC_W  = 30;

    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = 5;
    localparam int PC_W      = 5;

    localparam logic signed [POS_W-1:0] POS_MAX = 33'sd3019898880;
    localparam logic signed [POS_W-1:0] POS_MIN = -33'sd3019898880;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 36'sd3019898880;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -36'sd3019898880;
    localparam logic [K_W-1:0]          ONE_Q30 = 31'h4000_0000;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 2'd2;
    localparam logic [CFG_W-1:0] PROC_NOISE_RST = 32'd1073742;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 32'd107374182;
    localparam logic [CFG_W-1:0] INIT_VAR_RST   = 32'd1073741824;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
    localparam logic [OP_W-1:0] OP_PRED      = 4'd2;
    localparam logic [OP_W-1:0] OP_DEN       = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV       = 4'd4;
    localparam logic [OP_W-1:0] OP_INNOV_LON = 4'd5;
    localparam logic [OP_W-1:0] OP_INNOV_LAT = 4'd6;
    localparam logic [OP_W-1:0] OP_LOAD_P    = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_LO    = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_HI    = 4'd9;
    localparam logic [OP_W-1:0] OP_ACC       = 4'd10;
    localparam logic [OP_W-1:0] OP_ROUND     = 4'd11;
    localparam logic [OP_W-1:0] OP_CORR_LON  = 4'd12;
    localparam logic [OP_W-1:0] OP_CORR_LAT  = 4'd13;
    localparam logic [OP_W-1:0] OP_VAR_WB    = 4'd14;
    localparam logic [OP_W-1:0] OP_EMIT      = 4'd15;

    // Jump conditions: jump to target when true, else advance
    localparam int JC_W = 2;
    localparam logic [JC_W-1:0] JC_NEXT     = 2'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS   = 2'd1;
    localparam logic [JC_W-1:0] JC_CNT_NZ   = 2'd2;
    localparam logic [JC_W-1:0] JC_UNPRIMED = 2'd3;

    // Jump targets
    localparam logic [PC_W-1:0] PC_WAIT = 5'd0;
    localparam logic [PC_W-1:0] PC_DIV  = 5'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            use_one_minus_k;  // multiplier takes 1 - k instead of k
        logic [JC_W-1:0] jcond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic hold;     // current step waits on a handshake
        logic primed;   // first fix already loaded
    } dp_status_t;

    function automatic uword_t uw(input logic [OP_W-1:0] op, input logic b,
                                  input logic [JC_W-1:0] jc, input logic [PC_W-1:0] tgt);
        uword_t w;
        w.op              = op;
        w.use_one_minus_k = b;
        w.jcond           = jc;
        w.target          = tgt;
        return w;
    endfunction

    // Control store: one word per step
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = uw(OP_ACCEPT,    1'b0, JC_UNPRIMED, PC_WAIT);
            5'd1:    w = uw(OP_PRED,      1'b0, JC_NEXT,     PC_WAIT);
            5'd2:    w = uw(OP_DEN,       1'b0, JC_NEXT,     PC_WAIT);
            5'd3:    w = uw(OP_DIV,       1'b0, JC_CNT_NZ,   PC_DIV);
            5'd4:    w = uw(OP_INNOV_LON, 1'b0, JC_NEXT,     PC_WAIT);
            5'd5:    w = uw(OP_MUL_LO,    1'b0, JC_NEXT,     PC_WAIT);
            5'd6:    w = uw(OP_MUL_HI,    1'b0, JC_NEXT,     PC_WAIT);
            5'd7:    w = uw(OP_ACC,       1'b0, JC_NEXT,     PC_WAIT);
            5'd8:    w = uw(OP_ROUND,     1'b0, JC_NEXT,     PC_WAIT);
            5'd9:    w = uw(OP_CORR_LON,  1'b0, JC_NEXT,     PC_WAIT);
            5'd10:   w = uw(OP_INNOV_LAT, 1'b0, JC_NEXT,     PC_WAIT);
            5'd11:   w = uw(OP_MUL_LO,    1'b0, JC_NEXT,     PC_WAIT);
            5'd12:   w = uw(OP_MUL_HI,    1'b0, JC_NEXT,     PC_WAIT);
            5'd13:   w = uw(OP_ACC,       1'b0, JC_NEXT,     PC_WAIT);
            5'd14:   w = uw(OP_ROUND,     1'b0, JC_NEXT,     PC_WAIT);
            5'd15:   w = uw(OP_CORR_LAT,  1'b0, JC_NEXT,     PC_WAIT);
            5'd16:   w = uw(OP_LOAD_P,    1'b0, JC_NEXT,     PC_WAIT);
            5'd17:   w = uw(OP_MUL_LO,    1'b1, JC_NEXT,     PC_WAIT);
            5'd18:   w = uw(OP_MUL_HI,    1'b1, JC_NEXT,     PC_WAIT);
            5'd19:   w = uw(OP_ACC,       1'b0, JC_NEXT,     PC_WAIT);
            5'd20:   w = uw(OP_ROUND,     1'b0, JC_NEXT,     PC_WAIT);
            5'd21:   w = uw(OP_VAR_WB,    1'b0, JC_NEXT,     PC_WAIT);
            5'd22:   w = uw(OP_EMIT,      1'b0, JC_ALWAYS,   PC_WAIT);
            default: w = uw(OP_NOP,       1'b0, JC_ALWAYS,   PC_WAIT);
        endcase
        return w;
    endfunction

    // Saturate a widened position to the legal range
    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUM_MAX) begin
            r = POS_MAX;
        end else if (v < SUM_MIN) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/pkf_sequencer.sv @@
// Step counter, loop counter and branch logic of the filter's microcode engine.
// Depends on pkf_pkg (control store, control word and status types).
module pkf_sequencer
    import pkf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_status_t status,
    output uword_t     uword
);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             jump;

    assign uword = ucode_rom(pc_reg);

    always_comb begin
        case (uword.jcond)
            JC_NEXT:     jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_CNT_NZ:   jump = (cnt_reg != '0);
            JC_UNPRIMED: jump = !status.primed;
            default:     jump = 1'b0;
        endcase

        if (status.hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uword.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end

        cnt_next = cnt_reg;
        if (uword.op == OP_DEN) begin
            cnt_next = CNT_W'(DIV_STEPS - 1);
        end else if (uword.op == OP_DIV && cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_WAIT;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/pkf_datapath.sv @@
// Registers, divider step, shared multiplier and output register of the filter.
// Depends on pkf_pkg; driven one control word per cycle by pkf_sequencer.
module pkf_datapath
    import pkf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  uword_t                  uword,
    output dp_status_t              status,
    input  logic [CFG_W-1:0]        process_noise,
    input  logic [CFG_W-1:0]        measurement_noise,
    input  logic [CFG_W-1:0]        initial_variance,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_meas_longitude,
    input  logic signed [POS_W-1:0] s_meas_latitude,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_filt_longitude,
    output logic signed [POS_W-1:0] m_filt_latitude
);

    logic                    primed_reg;
    logic signed [POS_W-1:0] est_lon_reg, est_lat_reg;
    logic signed [POS_W-1:0] meas_lon_reg, meas_lat_reg;
    logic [VAR_W-1:0]        var_reg;
    logic [VAR_W-1:0]        p_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [K_W-1:0]          k_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       mul_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [D_W-1:0]          d_reg;
    logic                    m_valid_reg;
    logic signed [POS_W-1:0] out_lon_reg, out_lat_reg;

    logic                    s_fire, out_busy;
    logic signed [POS_W-1:0] clamp_lon, clamp_lat;
    logic [VAR_W:0]          p_sum;
    logic [VAR_W-1:0]        p_sat;
    logic [DEN_W-1:0]        den_sum;
    logic                    rem_ge;
    logic [REM_W-1:0]        rem_diff, rem_sel, rem_next;
    logic [K_W-1:0]          k_next, k_eff, one_minus_k, mul_b;
    logic [MLO_W-1:0]        mul_a;
    logic [PROD_W-1:0]       mul_prod;
    logic signed [POS_W-1:0] innov_meas, innov_est, corr_est;
    logic [DIFF_W-1:0]       diff, diff_mag;
    logic [D_W:0]            delta;
    logic [SUM_W-1:0]        corr_sum;
    logic signed [POS_W-1:0] corr_clamped;
    logic [D_W-1:0]          d_next;

    assign s_ready  = (uword.op == OP_ACCEPT);
    assign s_fire   = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;

    assign status.hold   = (uword.op == OP_ACCEPT && !s_valid) ||
                           (uword.op == OP_EMIT && out_busy);
    assign status.primed = primed_reg;

    assign clamp_lon = clamp_pos(SUM_W'(s_meas_longitude));
    assign clamp_lat = clamp_pos(SUM_W'(s_meas_latitude));

    // Prediction and gain denominator
    assign p_sum   = {1'b0, var_reg} + {1'b0, process_noise};
    assign p_sat   = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
    assign den_sum = {1'b0, p_reg} + {1'b0, measurement_noise};

    // One restoring-division step per cycle
    assign rem_ge   = (rem_reg >= {1'b0, den_reg});
    assign rem_diff = rem_reg - {1'b0, den_reg};
    assign rem_sel  = rem_ge ? rem_diff : rem_reg;
    assign rem_next = {rem_sel[REM_W-2:0], 1'b0};
    assign k_next   = {k_reg[K_W-2:0], rem_ge};

    // Zero denominator forces a zero gain
    assign k_eff       = (den_reg == '0) ? '0 : k_reg;
    assign one_minus_k = ONE_Q30 - k_eff;
    assign mul_b       = uword.use_one_minus_k ? one_minus_k : k_eff;
    assign mul_a       = (uword.op == OP_MUL_HI) ? MLO_W'(mag_reg[MAG_W-1:MLO_W])
                                                 : mag_reg[MLO_W-1:0];
    assign mul_prod    = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Innovation of the selected axis
    assign innov_meas = (uword.op == OP_INNOV_LAT) ? meas_lat_reg : meas_lon_reg;
    assign innov_est  = (uword.op == OP_INNOV_LAT) ? est_lat_reg : est_lon_reg;
    assign diff       = DIFF_W'(innov_meas) - DIFF_W'(innov_est);
    assign diff_mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

    // Round half away from zero: round the magnitude, then apply the sign
    assign d_next = D_W'(acc_reg[ACC_W-1:FRAC_W]) + D_W'(acc_reg[FRAC_W-1]);

    assign corr_est     = (uword.op == OP_CORR_LAT) ? est_lat_reg : est_lon_reg;
    assign delta        = neg_reg ? (~{1'b0, d_reg} + 1'b1) : {1'b0, d_reg};
    assign corr_sum     = SUM_W'(corr_est) + SUM_W'($signed(delta));
    assign corr_clamped = clamp_pos($signed(corr_sum));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // the output step reloads the register itself
            if (m_valid_reg && m_ready && uword.op != OP_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (uword.op)
                OP_ACCEPT: begin
                    if (s_fire) begin
                        meas_lon_reg <= clamp_lon;
                        meas_lat_reg <= clamp_lat;
                        if (!primed_reg) begin
                            est_lon_reg <= clamp_lon;
                            est_lat_reg <= clamp_lat;
                            var_reg     <= initial_variance;
                            primed_reg  <= 1'b1;
                        end
                    end
                end
                OP_PRED: p_reg <= p_sat;
                OP_DEN: begin
                    den_reg <= den_sum;
                    rem_reg <= REM_W'(p_reg);
                    k_reg   <= '0;
                end
                OP_DIV: begin
                    rem_reg <= rem_next;
                    k_reg   <= k_next;
                end
                OP_INNOV_LON, OP_INNOV_LAT: begin
                    mag_reg <= diff_mag[MAG_W-1:0];
                    neg_reg <= diff[DIFF_W-1];
                end
                OP_LOAD_P: begin
                    mag_reg <= MAG_W'(p_reg);
                    neg_reg <= 1'b0;
                end
                OP_MUL_LO: mul_reg <= mul_prod;
                OP_MUL_HI: begin
                    acc_reg <= ACC_W'(mul_reg);
                    mul_reg <= mul_prod;
                end
                OP_ACC:      acc_reg <= acc_reg + (ACC_W'(mul_reg) << MLO_W);
                OP_ROUND:    d_reg <= d_next;
                OP_CORR_LON: est_lon_reg <= corr_clamped;
                OP_CORR_LAT: est_lat_reg <= corr_clamped;
                OP_VAR_WB:   var_reg <= (d_reg[D_W-1:VAR_W] != '0) ? '1 : d_reg[VAR_W-1:0];
                OP_EMIT: begin
                    if (!out_busy) begin
                        out_lon_reg <= est_lon_reg;
                        out_lat_reg <= est_lat_reg;
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filt_longitude = out_lon_reg;
    assign m_filt_latitude  = out_lat_reg;

endmodule

@@ rtl/position_kalman_filter_2d.sv @@
// Top level of the 2-D constant-position Kalman filter for position fixes.
// Depends on pkf_pkg, pkf_sequencer and pkf_datapath.
//
// Usage:
//   Input channel s_*: one request carries a measured longitude and latitude,
//   signed Q9.24 degrees; values beyond +/-180 degrees are clamped on entry.
//   Result channel m_*: one filtered position per request, except the first
//   request after reset, which only loads the estimate and returns nothing.
//   Configuration channel cfg_*: writes process noise (index 0), measurement
//   noise (index 1) and initial variance (index 2), unsigned Q2.30; other
//   indexes are dropped. cfg_ready is always high. Write only while idle.
// Sequence:
//   A request runs through the microcode sequencer in order: 1 accept step,
//   2 steps for predicted variance and denominator, 31 steps of the
//   one-bit-per-cycle gain divider, 6 steps per axis and 6 for the variance
//   through one shared 17x31 multiplier, and 1 output step. The priming
//   request uses only the accept step.
// Reset (aresetn low, synchronous): registers return to their reset values,
//   the sequencer returns to its accept step and the filter is unprimed.
// Stall: the output register holds a result until taken; the next request
//   is accepted and computed meanwhile, and the sequencer holds at its
//   output step only if the earlier result is still waiting.
module position_kalman_filter_2d
    import pkf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_meas_longitude,
    input  logic signed [POS_W-1:0] s_meas_latitude,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_filt_longitude,
    output logic signed [POS_W-1:0] m_filt_latitude
);

    logic [CFG_W-1:0] proc_noise_reg, meas_noise_reg, init_var_reg;
    uword_t           uword;
    dp_status_t       status;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_noise_reg <= PROC_NOISE_RST;
            meas_noise_reg <= MEAS_NOISE_RST;
            init_var_reg   <= INIT_VAR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PROC_NOISE: proc_noise_reg <= cfg_data;
                CFG_MEAS_NOISE: meas_noise_reg <= cfg_data;
                CFG_INIT_VAR:   init_var_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Microcode engine: step counter, division loop counter and branches
    pkf_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    // Datapath: estimate state, divider, multiplier and output register
    pkf_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .uword             (uword),
        .status            (status),
        .process_noise     (proc_noise_reg),
        .measurement_noise (meas_noise_reg),
        .initial_variance  (init_var_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_meas_longitude  (s_meas_longitude),
        .s_meas_latitude   (s_meas_latitude),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_filt_longitude  (m_filt_longitude),
        .m_filt_latitude   (m_filt_latitude)
    );

endmodule

@@ rtl/pkf_checker.sv @@
// Port-level checks of the position Kalman filter, bound to its top level.
// Depends on pkf_pkg and position_kalman_filter_2d.
module pkf_checker
    import pkf_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [POS_W-1:0] m_filt_longitude,
    input logic signed [POS_W-1:0] m_filt_latitude
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filt_longitude)
                                && $stable(m_filt_latitude))
        else $error("result changed while stalled");

    // Results stay inside the saturation range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_filt_longitude <= POS_MAX && m_filt_longitude >= POS_MIN
                    && m_filt_latitude <= POS_MAX && m_filt_latitude >= POS_MIN)
        else $error("result out of range");

    // A new result is loaded only from the output step, never while accepting
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while input side was accepting");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind position_kalman_filter_2d pkf_checker u_pkf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filt_longitude (m_filt_longitude),
    .m_filt_latitude  (m_filt_latitude)
);
